/* sv/sug_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the arctangent table for the spherical uv generator
// no dependencies

package sug_pkg;

  localparam int unsigned CoordFracBits    = 16;
  localparam int unsigned CordicIterations = 16;
  localparam int unsigned AtanTabLen       = 24;
  localparam int unsigned AtanIdxW         = $clog2(AtanTabLen);
  localparam int unsigned AtanValW         = 30;
  localparam int unsigned TolW             = 16;
  localparam int unsigned CoordW           = 32;
  // cordic vector and angle widths, angles in 2^-32 turn
  localparam int unsigned VecW             = 36;
  localparam int unsigned AngW             = 35;

  localparam logic signed [AngW-1:0] HalfTurn    = {{(AngW-32){1'b0}}, 32'h8000_0000};
  localparam logic signed [AngW-1:0] QuarterTurn = {{(AngW-31){1'b0}}, 31'h4000_0000};

  typedef enum logic {
    ActScan    = 1'b0,
    ActConvert = 1'b1
  } sug_action_e;

  typedef struct packed {
    sug_action_e              action;
    logic                     first_vertex;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] tex_u;
    logic signed [CoordW-1:0] tex_v;
  } sug_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] uv_u;
    logic signed [CoordW-1:0] uv_v;
    logic                     all_zero;
    logic                     generated;
  } sug_out_t;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [AtanValW-1:0] sug_atan(input logic [AtanIdxW-1:0] idx);
    logic [AtanValW-1:0] val;
    unique case (idx)
      5'd0:    val = 30'd536870912;
      5'd1:    val = 30'd316933406;
      5'd2:    val = 30'd167458907;
      5'd3:    val = 30'd85004756;
      5'd4:    val = 30'd42667331;
      5'd5:    val = 30'd21354465;
      5'd6:    val = 30'd10679838;
      5'd7:    val = 30'd5340245;
      5'd8:    val = 30'd2670163;
      5'd9:    val = 30'd1335087;
      5'd10:   val = 30'd667544;
      5'd11:   val = 30'd333772;
      5'd12:   val = 30'd166886;
      5'd13:   val = 30'd83443;
      5'd14:   val = 30'd41722;
      5'd15:   val = 30'd20861;
      5'd16:   val = 30'd10430;
      5'd17:   val = 30'd5215;
      5'd18:   val = 30'd2608;
      5'd19:   val = 30'd1304;
      5'd20:   val = 30'd652;
      5'd21:   val = 30'd326;
      5'd22:   val = 30'd163;
      5'd23:   val = 30'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* sv/sug_cordic.sv */
`timescale 1ns / 1ps
// iterative vectoring cordic: angle of vector (a, b), one micro-rotation per cycle
// depends on sug_pkg

module sug_cordic #(
  parameter int unsigned CordicIterations = sug_pkg::CordicIterations
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [sug_pkg::VecW-1:0]  a_i,
  input  logic signed [sug_pkg::VecW-1:0]  b_i,
  output logic                             done_o,
  output logic signed [sug_pkg::AngW-1:0]  angle_o
);
  import sug_pkg::*;

  localparam int unsigned NumSteps = (CordicIterations > AtanTabLen) ? AtanTabLen
                                                                     : CordicIterations;
  localparam int unsigned CntW = $clog2(NumSteps);

  typedef enum logic [1:0] {
    CorIdle = 2'b01,
    CorRun  = 2'b10
  } cor_state_e;

  cor_state_e               state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic signed [VecW-1:0]   a_q, a_d, b_q, b_d;
  logic signed [AngW-1:0]   ang_q, ang_d;
  logic signed [VecW-1:0]   da, db;
  logic signed [AngW-1:0]   step_ang;

  assign da       = b_q >>> cnt_q;
  assign db       = a_q >>> cnt_q;
  assign step_ang = signed'({{(AngW-AtanValW){1'b0}}, sug_atan(AtanIdxW'(cnt_q))});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    ang_d   = ang_q;
    unique case (state_q)
      CorIdle: begin
        if (start_i) begin
          if (a_i == '0) begin
            // vertical vector or zero vector
            if (b_i > 0) begin
              ang_d = QuarterTurn;
            end else if (b_i < 0) begin
              ang_d = -QuarterTurn;
            end else begin
              ang_d = '0;
            end
            done_d = 1'b1;
          end else if (b_i == '0) begin
            ang_d  = (a_i > 0) ? '0 : HalfTurn;
            done_d = 1'b1;
          end else begin
            // fold the left half plane over
            if (a_i < 0) begin
              ang_d = b_i[VecW-1] ? -HalfTurn : HalfTurn;
              a_d   = -a_i;
              b_d   = -b_i;
            end else begin
              ang_d = '0;
              a_d   = a_i;
              b_d   = b_i;
            end
            cnt_d   = '0;
            state_d = CorRun;
          end
        end
      end
      CorRun: begin
        if (!b_q[VecW-1]) begin
          a_d   = a_q + da;
          b_d   = b_q - db;
          ang_d = ang_q + step_ang;
        end else begin
          a_d   = a_q - da;
          b_d   = b_q + db;
          ang_d = ang_q - step_ang;
        end
        if (cnt_q == CntW'(NumSteps - 1)) begin
          done_d  = 1'b1;
          state_d = CorIdle;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = CorIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CorIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    ang_q <= ang_d;
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

/* sv/sug_isqrt.sv */
`timescale 1ns / 1ps
// horizontal radius unit: floor(sqrt(ax^2 + az^2)) with one shared multiplier
// and a restoring square root, one result bit per cycle; depends on sug_pkg

module sug_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sug_pkg::CoordW-1:0]    ax_i,
  input  logic [sug_pkg::CoordW-1:0]    az_i,
  output logic                          done_o,
  output logic [sug_pkg::CoordW-1:0]    root_o
);
  import sug_pkg::*;

  localparam int unsigned SqW = 2 * CoordW;

  typedef enum logic [4:0] {
    SqIdle = 5'b00001,
    SqMulX = 5'b00010,
    SqMulZ = 5'b00100,
    SqSum  = 5'b01000,
    SqRoot = 5'b10000
  } sq_state_e;

  sq_state_e          state_q, state_d;
  logic               done_q, done_d;
  logic [CoordW-1:0]  ax_q, ax_d, az_q, az_d;
  logic [SqW-1:0]     prod_q, prod_d, sq_q, sq_d;
  logic [SqW-1:0]     rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [CoordW-1:0]  mul_op;
  logic [SqW-1:0]     mul_res;
  logic [SqW-1:0]     trial;

  assign mul_op  = (state_q == SqMulX) ? ax_q : az_q;
  assign mul_res = mul_op * mul_op;
  assign trial   = root_q + bit_q;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ax_d    = ax_q;
    az_d    = az_q;
    prod_d  = prod_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    root_d  = root_q;
    bit_d   = bit_q;
    unique case (state_q)
      SqIdle: begin
        if (start_i) begin
          ax_d    = ax_i;
          az_d    = az_i;
          state_d = SqMulX;
        end
      end
      SqMulX: begin
        prod_d  = mul_res;
        state_d = SqMulZ;
      end
      SqMulZ: begin
        sq_d    = prod_q;
        prod_d  = mul_res;
        state_d = SqSum;
      end
      SqSum: begin
        rem_d   = sq_q + prod_q;
        root_d  = '0;
        bit_d   = {2'b01, {(SqW-2){1'b0}}};
        state_d = SqRoot;
      end
      SqRoot: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          done_d  = 1'b1;
          state_d = SqIdle;
        end
      end
      default: state_d = SqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    az_q   <= az_d;
    prod_q <= prod_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[CoordW-1:0];

endmodule

/* sv/spherical_uv_generator.sv */
`timescale 1ns / 1ps
// spherical uv generator top: all-zero texcoord scan, sequencer, output register
// depends on sug_pkg, sug_cordic, sug_isqrt
//
//   channel  | direction | handshake                | payload
//   in       | input     | in_valid_i / in_stall_o  | in_item_i  (sug_in_t)
//   out      | output    | out_valid_o / out_stall_i| out_item_o (sug_out_t)
//   cfg      | input     | cfg_we_i                 | cfg_data_i (zero tolerance)
//
// scan items, pass-through items and zero-length positions give their result
// in the cycle after acceptance. a generated uv passes the root, second-angle
// and finish states: the radius square root runs beside the first cordic pass,
// then the cordic is reused for the elevation angle. one item is in flight at a
// time; input is stalled while it computes or while a stalled result is held.
// reset sets the all-zero flag and clears the tolerance.

module spherical_uv_generator #(
  parameter int unsigned CoordFracBits    = sug_pkg::CoordFracBits,
  parameter int unsigned CordicIterations = sug_pkg::CordicIterations
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sug_pkg::sug_in_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sug_pkg::sug_out_t           out_item_o,
  input  logic                        cfg_we_i,
  input  logic [sug_pkg::TolW-1:0]    cfg_data_i
);
  import sug_pkg::*;

  localparam int unsigned QW = AngW + 3;
  localparam logic signed [QW-1:0] FullTurnQ = {{(QW-33){1'b0}}, 33'h1_0000_0000};

  typedef enum logic [3:0] {
    TopIdle = 4'b0001,
    TopRoot = 4'b0010,
    TopAng2 = 4'b0100,
    TopFin  = 4'b1000
  } top_state_e;

  top_state_e               state_q, state_d;
  logic                     flag_q, flag_d;
  logic [TolW-1:0]          tol_q;
  logic                     out_valid_q, out_valid_d;
  sug_out_t                 out_q, out_d;
  logic signed [CoordW-1:0] y_q, y_d;
  logic signed [AngW-1:0]   a1_q, a1_d, a2_q, a2_d;

  logic                     in_fire;
  logic                     out_free;
  logic                     pos_zero;
  logic                     needs_calc;
  logic                     scan_flag;
  logic [CoordW-1:0]        abs_u, abs_v, abs_x, abs_z;
  logic                     cor_start, cor_done;
  logic signed [VecW-1:0]   cor_a, cor_b;
  logic signed [AngW-1:0]   cor_angle;
  logic                     sq_done;
  logic [CoordW-1:0]        sq_root;
  logic signed [QW-1:0]     q_u, q_v;

  function automatic logic [CoordW-1:0] abs_coord(input logic signed [CoordW-1:0] v);
    return v[CoordW-1] ? CoordW'(~v + 1'b1) : CoordW'(v);
  endfunction

  // clamp to [0, one turn], then round half up to the coordinate grid
  function automatic logic [CoordW-1:0] to_coord(input logic signed [QW-1:0] q);
    logic [32:0] c;
    logic [33:0] s;
    if (q[QW-1]) begin
      c = '0;
    end else if (q > FullTurnQ) begin
      c = 33'h1_0000_0000;
    end else begin
      c = q[32:0];
    end
    s = {1'b0, c} + (34'd1 << (31 - CoordFracBits));
    return CoordW'(s >> (32 - CoordFracBits));
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != TopIdle) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign abs_u = abs_coord(in_item_i.tex_u);
  assign abs_v = abs_coord(in_item_i.tex_v);
  assign abs_x = abs_coord(in_item_i.pos_x);
  assign abs_z = abs_coord(in_item_i.pos_z);

  assign scan_flag = (flag_q || in_item_i.first_vertex)
                     && !(abs_u > CoordW'(tol_q)) && !(abs_v > CoordW'(tol_q));
  assign pos_zero  = (in_item_i.pos_x == '0) && (in_item_i.pos_y == '0)
                     && (in_item_i.pos_z == '0);
  assign needs_calc = (in_item_i.action == ActConvert) && flag_q && !pos_zero;

  // cordic first takes azimuth (x, z), later elevation (radius, y)
  assign cor_start = (in_fire && needs_calc) || ((state_q == TopRoot) && sq_done);
  assign cor_a = (state_q == TopIdle) ? VecW'(in_item_i.pos_x)
                                      : signed'({{(VecW-CoordW){1'b0}}, sq_root});
  assign cor_b = (state_q == TopIdle) ? VecW'(in_item_i.pos_z) : VecW'(y_q);

  sug_cordic #(
    .CordicIterations(CordicIterations)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .a_i     (cor_a),
    .b_i     (cor_b),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  sug_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && needs_calc),
    .ax_i    (abs_x),
    .az_i    (abs_z),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign q_u = QW'(HalfTurn) + QW'(a1_q);
  assign q_v = QW'(HalfTurn) - (QW'(a2_q) <<< 1);

  always_comb begin
    state_d     = state_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    y_d         = y_q;
    a1_d        = a1_q;
    a2_d        = a2_q;
    unique case (state_q)
      TopIdle: begin
        if (in_fire) begin
          y_d = in_item_i.pos_y;
          if (in_item_i.action == ActScan) begin
            flag_d          = scan_flag;
            out_d.uv_u      = '0;
            out_d.uv_v      = '0;
            out_d.all_zero  = scan_flag;
            out_d.generated = 1'b0;
            out_valid_d     = 1'b1;
          end else if (!flag_q) begin
            out_d.uv_u      = in_item_i.tex_u;
            out_d.uv_v      = in_item_i.tex_v;
            out_d.all_zero  = flag_q;
            out_d.generated = 1'b0;
            out_valid_d     = 1'b1;
          end else if (pos_zero) begin
            out_d.uv_u      = signed'(CoordW'(1) << (CoordFracBits - 1));
            out_d.uv_v      = '0;
            out_d.all_zero  = flag_q;
            out_d.generated = 1'b1;
            out_valid_d     = 1'b1;
          end else begin
            state_d = TopRoot;
          end
        end
      end
      TopRoot: begin
        // azimuth finishes well before the radius
        if (cor_done) begin
          a1_d = cor_angle;
        end
        if (sq_done) begin
          state_d = TopAng2;
        end
      end
      TopAng2: begin
        if (cor_done) begin
          a2_d    = cor_angle;
          state_d = TopFin;
        end
      end
      TopFin: begin
        out_d.uv_u      = signed'(to_coord(q_u));
        out_d.uv_v      = signed'(to_coord(q_v));
        out_d.all_zero  = flag_q;
        out_d.generated = 1'b1;
        out_valid_d     = 1'b1;
        state_d         = TopIdle;
      end
      default: state_d = TopIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TopIdle;
      flag_q      <= 1'b1;
      tol_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    y_q   <= y_d;
    a1_q  <= a1_d;
    a2_q  <= a2_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
